// ----- rtl/esc_rx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the esc/stx framed message receiver
// no dependencies
package esc_rx_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;

	localparam logic [7:0] SYM_ESC = 8'h1B;
	localparam logic [7:0] SYM_STX = 8'h02;
	localparam logic [7:0] SYM_ETX = 8'h03;

	// position of the first payload byte in the frame store
	localparam int PAYLOAD_START = 4;

	typedef enum logic [0:0] {
		ST_RECV,
		ST_DELIVER
	} ctl_state_t;

	typedef struct packed {
		logic accept_en;
		logic deliver_en;
	} ctl_cmd_t;

	typedef struct packed {
		logic frame_ready;
		logic deliver_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/esc_rx_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// controller: switches between byte collection and frame delivery
// depends on esc_rx_pkg
module esc_rx_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire esc_rx_pkg::dp_stat_t stat,
	output esc_rx_pkg::ctl_cmd_t      cmd
);
	import esc_rx_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RECV: begin
				if (stat.frame_ready) state_d = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (stat.deliver_done) state_d = ST_RECV;
			end
			default: state_d = ST_RECV;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_RECV:    cmd.accept_en = 1'b1;
			ST_DELIVER: cmd.deliver_en = 1'b1;
			default:    cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/esc_rx_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// datapath: frame store, byte counter, header/trailer detection, read stage and output register
// depends on esc_rx_pkg
module esc_rx_dpath #(
	parameter int BUFFER_DEPTH = esc_rx_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire esc_rx_pkg::ctl_cmd_t cmd,
	output esc_rx_pkg::dp_stat_t      stat,
	input  wire logic                 in_valid,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [7:0]                out_cmd_hi,
	output logic [7:0]                out_cmd_lo,
	output logic [7:0]                out_payload,
	output logic                      out_pvalid,
	output logic [5:0]                out_index,
	output logic                      out_last
);
	import esc_rx_pkg::*;

	localparam int CW = $clog2(BUFFER_DEPTH);

	logic [7:0]    store_q [BUFFER_DEPTH];
	logic [CW-1:0] count_q, count_d, ptr_q, end_q;
	logic [7:0]    prev_q, cmd_hi_q, cmd_lo_q;
	logic          empty_q;

	logic          accept, hit_trailer, esc_prev, rd_en, is_last, load;
	logic          frame_ready, deliver_done;

	logic          rdv_s1, rlast_s1, rpv_s1;
	logic [7:0]    rdata_s1, rch_s1, rcl_s1;
	logic [5:0]    ridx_s1;

	logic          m_valid_q, m_pvalid_q, m_last_q;
	logic [7:0]    m_ch_q, m_cl_q, m_data_q;
	logic [5:0]    m_idx_q;

	assign accept   = in_valid & cmd.accept_en;
	assign esc_prev = (prev_q == SYM_ESC);

	// opening check, store full, restart on a new header, trailer
	always_comb begin
		hit_trailer = 1'b0;
		if (count_q == '0) begin
			count_d = (in_byte == SYM_ESC) ? CW'(1) : '0;
		end else if (count_q == CW'(1)) begin
			count_d = (in_byte == SYM_STX) ? CW'(2) : '0;
		end else if (count_q == CW'(BUFFER_DEPTH - 1)) begin
			count_d = '0;
		end else if (esc_prev && in_byte == SYM_STX) begin
			count_d = CW'(2);
		end else if (esc_prev && in_byte == SYM_ETX) begin
			count_d     = '0;
			hit_trailer = 1'b1;
		end else begin
			count_d = count_q + CW'(1);
		end
	end

	// frames shorter than six bytes end without delivery
	assign frame_ready = accept & hit_trailer & (count_q >= CW'(5));

	assign load         = rdv_s1 & (~m_valid_q | out_ready);
	assign rd_en        = cmd.deliver_en & (~rdv_s1 | load);
	assign is_last      = empty_q | (ptr_q == end_q);
	assign deliver_done = rd_en & is_last;

	always_comb begin
		stat.frame_ready  = frame_ready;
		stat.deliver_done = deliver_done;
	end

	always_ff @(posedge clk) begin
		if (accept) store_q[count_q] <= in_byte;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= store_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q <= in_byte;
			if (count_q == CW'(2)) cmd_hi_q <= in_byte;
			if (count_q == CW'(3)) cmd_lo_q <= in_byte;
		end
		if (frame_ready) begin
			ptr_q   <= CW'(PAYLOAD_START);
			end_q   <= count_q - CW'(2);
			empty_q <= (count_q == CW'(5));
		end else if (rd_en) begin
			ptr_q <= ptr_q + CW'(1);
		end
	end

	// read stage, also serves as skid slot in front of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else if (rd_en) begin
			rdv_s1 <= 1'b1;
		end else if (load) begin
			rdv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rlast_s1 <= is_last;
			rpv_s1   <= ~empty_q;
			ridx_s1  <= 6'(ptr_q - CW'(PAYLOAD_START));
			rch_s1   <= cmd_hi_q;
			rcl_s1   <= cmd_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_ch_q     <= rch_s1;
			m_cl_q     <= rcl_s1;
			m_data_q   <= rpv_s1 ? rdata_s1 : 8'h00;
			m_pvalid_q <= rpv_s1;
			m_idx_q    <= rpv_s1 ? ridx_s1 : 6'd0;
			m_last_q   <= rlast_s1;
		end
	end

	assign out_valid   = m_valid_q;
	assign out_cmd_hi  = m_ch_q;
	assign out_cmd_lo  = m_cl_q;
	assign out_payload = m_data_q;
	assign out_pvalid  = m_pvalid_q;
	assign out_index   = m_idx_q;
	assign out_last    = m_last_q;

endmodule

`default_nettype wire

// ----- rtl/esc_framed_message_receiver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// input: one byte per cycle while collecting; ready drops from the trailer item until the
// last payload read is issued. output: the first result passes the read stage and then the
// output register, then one result per cycle while m_axis_tready is high, set by the single
// read port of the frame store; up to BUFFER_DEPTH-7 results per frame
// reset: arst_n clears the byte count, the controller and the read-stage and output valid flags; store is not cleared
module esc_framed_message_receiver_core #(
	parameter int BUFFER_DEPTH = esc_rx_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [7:0] command_high, [15:8] command_low,
	                                         // [23:16] payload_byte, [29:24] payload_index
	output logic [0:0]       m_axis_tuser,   // [0] payload_valid
	output logic             m_axis_tlast
);
	import esc_rx_pkg::*;

	ctl_cmd_t   cmd;
	dp_stat_t   stat;
	logic [7:0] cmd_hi, cmd_lo, payload;
	logic [5:0] index;
	logic       pvalid;

	esc_rx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	esc_rx_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_valid    (s_axis_tvalid),
		.in_byte     (s_axis_tdata),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_cmd_hi  (cmd_hi),
		.out_cmd_lo  (cmd_lo),
		.out_payload (payload),
		.out_pvalid  (pvalid),
		.out_index   (index),
		.out_last    (m_axis_tlast)
	);

	assign s_axis_tready = cmd.accept_en;
	assign m_axis_tdata  = {2'b00, index, payload, cmd_lo, cmd_hi};
	assign m_axis_tuser  = pvalid;

endmodule

`default_nettype wire

// ----- rtl/esc_rx_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for the framed message receiver, bound to the top level
// depends on esc_rx_pkg and esc_framed_message_receiver_core
module esc_rx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);
	import esc_rx_pkg::*;

	// input is only held off after an accepted trailer byte
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !(s_axis_tvalid && s_axis_tdata == SYM_ETX) |=> s_axis_tready)
		else $error("input ready dropped without a trailer item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// an empty-payload item is the whole frame
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tlast && m_axis_tdata[23:16] == 8'h00 && m_axis_tdata[29:24] == 6'd0)
		else $error("empty frame item malformed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
		else $error("pad bits set");

endmodule

bind esc_framed_message_receiver_core esc_rx_checker u_esc_rx_checker (.*);

`default_nettype wire
